// ===== sv/assert_macros.svh =====
// Assertion macros shared by the solver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked while out of reset.
`define TCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked while out of reset.
`define TCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/tcs_pkg.sv =====
// Shared types and saturating helpers for the tridiagonal solver.
package tcs_pkg;

  localparam int unsigned Q_W = 32;
  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_FDIV, S_MUL_FF, S_MUL_FY, S_SUBN, S_PIV, S_SQRT, S_YDIV,
    S_BINIT, S_BRD, S_BMUL, S_BSUB, S_BDIV, S_BOUT
  } state_t;

  // Exact subtraction saturated back to 32 bits.
  function automatic logic signed [Q_W-1:0] sat_sub(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] d;
    d = {a[Q_W-1], a} - {b[Q_W-1], b};
    if (d[Q_W] != d[Q_W-1]) begin
      return d[Q_W] ? Q_MIN : Q_MAX;
    end
    return d[Q_W-1:0];
  endfunction

endpackage

// ===== sv/tcs_mul.sv =====
// Fixed-point multiplier with a registered magnitude product and saturation.
module tcs_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic signed [tcs_pkg::Q_W-1:0]      a,
  input  logic signed [tcs_pkg::Q_W-1:0]      b,
  output logic signed [tcs_pkg::Q_W-1:0]      p
);
  import tcs_pkg::*;

  logic [Q_W-1:0]   ma, mb;
  logic [2*Q_W-1:0] prod_r;
  logic             neg_r;
  logic [2*Q_W-1:0] sh;

  // Magnitudes go through the multiplier; the sign is kept aside.
  assign ma = a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
  assign mb = b[Q_W-1] ? Q_W'(-b) : Q_W'(b);

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    neg_r  <= a[Q_W-1] ^ b[Q_W-1];
  end

  // Truncate toward zero, then saturate.
  always_comb begin
    sh = prod_r >> FRAC_BITS;
    if (sh >= (2*Q_W)'(64'h8000_0000)) begin
      p = neg_r ? Q_MIN : Q_MAX;
    end else if (neg_r) begin
      p = -$signed(sh[Q_W-1:0]);
    end else begin
      p = $signed(sh[Q_W-1:0]);
    end
  end

endmodule

// ===== sv/tcs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, saturating result.
module tcs_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [tcs_pkg::Q_W-1:0] a,
  input  logic signed [tcs_pkg::Q_W-1:0] b,
  output logic                           done,
  output logic signed [tcs_pkg::Q_W-1:0] q
);
  import tcs_pkg::*;

  localparam int DW = Q_W + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]  dq_r;
  logic [Q_W:0]   rem_r;
  logic [Q_W-1:0] mb_r;
  logic           neg_r, busy_r, done_r, az_r, apos_r;
  logic [CW-1:0]  cnt_r;
  logic [Q_W:0]   shifted;
  logic           ge;
  logic [Q_W-1:0] ma;

  assign ma      = a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
  assign shifted = {rem_r[Q_W-1:0], dq_r[DW-1]};
  assign ge      = shifted >= {1'b0, mb_r};

  // Control: the start pulse loads the counter with DW; the run ends, and done pulses, when it runs out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits shift out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r   <= {ma, FRAC_BITS'(0)};
      rem_r  <= '0;
      mb_r   <= b[Q_W-1] ? Q_W'(-b) : Q_W'(b);
      neg_r  <= a[Q_W-1] ^ b[Q_W-1];
      az_r   <= (a == '0);
      apos_r <= ~a[Q_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? shifted - {1'b0, mb_r} : shifted;
      dq_r  <= {dq_r[DW-2:0], ge};
    end
  end

  // Division by zero and overflow saturate.
  always_comb begin
    if (mb_r == '0) begin
      q = az_r ? '0 : (apos_r ? Q_MAX : Q_MIN);
    end else if (dq_r >= DW'(64'h8000_0000)) begin
      q = neg_r ? Q_MIN : Q_MAX;
    end else if (neg_r) begin
      q = -$signed(dq_r[Q_W-1:0]);
    end else begin
      q = $signed(dq_r[Q_W-1:0]);
    end
  end

  assign done = done_r;

endmodule

// ===== sv/tcs_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module tcs_sqrt #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tcs_pkg::Q_W-2:0]        s,
  output logic                           done,
  output logic [tcs_pkg::Q_W-2:0]        root
);
  import tcs_pkg::*;

  localparam int XW = Q_W - 1 + FRAC_BITS;
  localparam int SW = XW + (XW % 2);
  localparam int RW = SW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [SW-1:0]   x_r;
  logic [RW-1:0]   root_r;
  logic [RW+1:0]   rem_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r, done_r;
  logic [RW+3:0]   cand, trial;
  logic            ge;

  assign cand  = {rem_r, x_r[SW-1:SW-2]};
  assign trial = (RW+4)'({root_r, 2'b01});
  assign ge    = cand >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // One root bit per step from the next pair of radicand bits.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= SW'({s, FRAC_BITS'(0)});
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[SW-3:0], 2'b00};
      rem_r  <= ge ? (RW+2)'(cand - trial) : (RW+2)'(cand);
      root_r <= {root_r[RW-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = (Q_W-1)'(root_r);

endmodule

// ===== sv/tridiagonal_cholesky_solver_core.sv =====
// Tridiagonal Cholesky solver: sequencer, row stores and shared arithmetic units.
//
// Usage: write the constant off-diagonal entry through cfg_wr_en/cfg_wr_data
// while the block is idle. Then present one matrix row per input transaction
// (in_valid/in_ready), each with its diagonal and right-hand-side entry; the
// row flagged in_last_row closes the system. Rows produce no result until the
// last one, after which one result transaction per stored row is given on out_valid/
// out_ready, highest row first, with row 0 marked by out_last_result.
// Each accepted row is worked through by the bit-serial divider (used twice per
// row) and the square root unit before the next row is taken; row 0 needs one
// division only, and a non-positive pivot skips the square root. In the backward
// pass the divider sets the pace again, with one division per result. in_ready
// is high only while idle, so one row is in work at a time.
// Reset clears the row count, the error flag and the off-diagonal register;
// the row stores need no clearing. A stalled receiver simply holds the result
// in the output register and the sequencer waits.
module tridiagonal_cholesky_solver_core #(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic signed [tcs_pkg::Q_W-1:0] cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [tcs_pkg::Q_W-1:0] in_diag_value,
  input  logic signed [tcs_pkg::Q_W-1:0] in_rhs_value,
  input  logic                           in_last_row,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [5:0]                     out_row_index,
  output logic signed [tcs_pkg::Q_W-1:0] out_solution,
  output logic [tcs_pkg::Q_W-2:0]        out_pivot,
  output logic signed [tcs_pkg::Q_W-1:0] out_factor_offdiag,
  output logic                           out_last_result,
  output logic                           out_error_code
);
  import tcs_pkg::*;
  `include "assert_macros.svh"

  localparam int IW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);

  state_t state_r, state_nxt;

  logic signed [Q_W-1:0] offdiag_r, d_r, b_r, f_r, s_r, num_r, y_prev_r, xn_r;
  logic [Q_W-2:0]        piv_r, p_prev_r;
  logic                  last_r, err_r, first_r;
  logic [CW-1:0]         row_r;
  logic [IW-1:0]         idx_r;

  // Row stores.
  logic [Q_W-2:0]        pmem [MAX_ROWS];
  logic signed [Q_W-1:0] ymem [MAX_ROWS];
  logic signed [Q_W-1:0] fmem [MAX_ROWS];
  logic [Q_W-2:0]        p_rd_r;
  logic signed [Q_W-1:0] y_rd_r, f_rd_r;

  // Shared units.
  logic                  div_start, div_done, sqrt_start, sqrt_done;
  logic signed [Q_W-1:0] div_a, div_b, div_q, mul_a, mul_b, mul_p;
  logic [Q_W-2:0]        sqrt_root;

  logic                  in_acc;
  logic                  out_valid_r;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  tcs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .a(div_a), .b(div_b),
    .done(div_done), .q(div_q)
  );

  tcs_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .s(s_r[Q_W-2:0]),
    .done(sqrt_done), .root(sqrt_root)
  );

  tcs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .p(mul_p)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and unit controls.
  always_comb begin
    state_nxt  = state_r;
    div_start  = 1'b0;
    div_a      = offdiag_r;
    div_b      = $signed({1'b0, p_prev_r});
    sqrt_start = 1'b0;
    mul_a      = f_r;
    mul_b      = f_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (row_r >= CW'(MAX_ROWS)) begin
            state_nxt = in_last_row ? S_BINIT : S_IDLE;
          end else if (row_r == '0) begin
            state_nxt = S_PIV;
          end else begin
            div_start = 1'b1;
            state_nxt = S_FDIV;
          end
        end
      end
      S_FDIV: begin
        if (div_done) begin
          state_nxt = S_MUL_FF;
        end
      end
      S_MUL_FF: begin
        state_nxt = S_MUL_FY;
      end
      S_MUL_FY: begin
        mul_b     = y_prev_r;
        state_nxt = S_SUBN;
      end
      S_SUBN: begin
        state_nxt = S_PIV;
      end
      S_PIV: begin
        if (s_r <= 0) begin
          div_start = 1'b1;
          div_a     = num_r;
          div_b     = '0;
          state_nxt = S_YDIV;
        end else begin
          sqrt_start = 1'b1;
          state_nxt  = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          div_start = 1'b1;
          div_a     = num_r;
          div_b     = $signed({1'b0, sqrt_root});
          state_nxt = S_YDIV;
        end
      end
      S_YDIV: begin
        if (div_done) begin
          state_nxt = last_r ? S_BINIT : S_IDLE;
        end
      end
      S_BINIT: begin
        state_nxt = S_BRD;
      end
      S_BRD: begin
        state_nxt = S_BMUL;
      end
      S_BMUL: begin
        mul_a = f_rd_r;
        mul_b = xn_r;
        if (first_r) begin
          div_start = 1'b1;
          div_a     = y_rd_r;
          div_b     = $signed({1'b0, p_rd_r});
          state_nxt = S_BDIV;
        end else begin
          state_nxt = S_BSUB;
        end
      end
      S_BSUB: begin
        div_start = 1'b1;
        div_a     = sat_sub(y_rd_r, mul_p);
        div_b     = $signed({1'b0, p_rd_r});
        state_nxt = S_BDIV;
      end
      S_BDIV: begin
        if (div_done) begin
          state_nxt = S_BOUT;
        end
      end
      S_BOUT: begin
        if (out_ready) begin
          state_nxt = (idx_r == '0) ? S_IDLE : S_BRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers: configuration, row count, error flag, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offdiag_r   <= '0;
      row_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        offdiag_r <= cfg_wr_data;
      end
      if (state_r == S_PIV && s_r <= 0) begin
        err_r <= 1'b1;
      end
      if (state_r == S_YDIV && div_done) begin
        row_r <= row_r + 1'b1;
      end
      if (state_r == S_BDIV && div_done) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == S_BOUT && out_ready) begin
        out_valid_r <= 1'b0;
        if (idx_r == '0) begin
          row_r <= '0;
          err_r <= 1'b0;
        end
      end
    end
  end

  // Datapath registers of the forward and backward passes.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      d_r    <= in_diag_value;
      b_r    <= in_rhs_value;
      last_r <= in_last_row;
      s_r    <= in_diag_value;
      num_r  <= in_rhs_value;
    end
    case (state_r)
      S_FDIV: begin
        if (div_done) begin
          f_r <= div_q;
        end
      end
      S_MUL_FY: s_r   <= sat_sub(d_r, mul_p);
      S_SUBN:   num_r <= sat_sub(b_r, mul_p);
      S_PIV: begin
        if (s_r <= 0) begin
          piv_r <= '0;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          piv_r <= sqrt_root;
        end
      end
      S_YDIV: begin
        if (div_done) begin
          p_prev_r <= piv_r;
          y_prev_r <= div_q;
        end
      end
      S_BINIT: begin
        idx_r   <= IW'(row_r - 1'b1);
        first_r <= 1'b1;
      end
      S_BDIV: begin
        if (div_done) begin
          xn_r               <= div_q;
          out_row_index      <= 6'(idx_r);
          out_solution       <= div_q;
          out_pivot          <= p_rd_r;
          out_factor_offdiag <= first_r ? '0 : f_rd_r;
          out_last_result    <= (idx_r == '0);
          out_error_code     <= err_r;
        end
      end
      S_BOUT: begin
        if (out_ready) begin
          idx_r   <= idx_r - 1'b1;
          first_r <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Row stores: one write per store per cycle, registered reads.
  always_ff @(posedge clk) begin
    if (state_r == S_FDIV && div_done) begin
      fmem[IW'(row_r - 1'b1)] <= div_q;
    end
    if (state_r == S_YDIV && div_done) begin
      pmem[IW'(row_r)] <= piv_r;
      ymem[IW'(row_r)] <= div_q;
    end
    p_rd_r <= pmem[idx_r];
    y_rd_r <= ymem[idx_r];
    f_rd_r <= fmem[idx_r];
  end

  assign out_valid = out_valid_r;

  `TCS_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid_r, !in_ready,
                  "input taken while a result is pending")
  `TCS_ASSERT_NOW(a_row_in_range, clk, rst_n, out_valid_r,
                  CW'(out_row_index) < row_r, "result row beyond rows loaded")
  `TCS_ASSERT_NEXT(a_end_of_system, clk, rst_n,
                   out_valid_r && out_ready && out_last_result,
                   in_ready && row_r == '0 && !err_r, "system state not cleared")

endmodule

// ===== test/tb_tridiagonal_cholesky_solver_core.sv =====
// Self-checking testbench for the tridiagonal Cholesky solver core.
module tb_tridiagonal_cholesky_solver_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_DEPTH = 64;
  localparam int FRAC = 16;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;

  // One solved row as it should appear on the result channel.
  typedef struct {
    logic [5:0]         row;
    logic signed [31:0] x;
    logic [30:0]        piv;
    logic signed [31:0] fac;
    logic               last;
    logic               err;
  } solved_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic signed [tcs_pkg::Q_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [tcs_pkg::Q_W-1:0] in_diag_value = '0;
  logic signed [tcs_pkg::Q_W-1:0] in_rhs_value = '0;
  logic in_last_row = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] out_row_index;
  logic signed [tcs_pkg::Q_W-1:0] out_solution;
  logic [tcs_pkg::Q_W-2:0] out_pivot;
  logic signed [tcs_pkg::Q_W-1:0] out_factor_offdiag;
  logic out_last_result;
  logic out_error_code;

  // Shadow copy of the solver state.
  longint offdiag_q;
  longint pivot_mem [ROW_DEPTH];
  longint factor_mem [ROW_DEPTH];
  longint forward_mem [ROW_DEPTH];
  int rows_held;
  bit pivot_bad;

  solved_row_t solution_q[$];
  int fail_count = 0;
  bit idle_on = 1'b1;
  int sink_hold_req = 0;

  tridiagonal_cholesky_solver_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_diag_value(in_diag_value), .in_rhs_value(in_rhs_value),
    .in_last_row(in_last_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row_index(out_row_index), .out_solution(out_solution),
    .out_pivot(out_pivot), .out_factor_offdiag(out_factor_offdiag),
    .out_last_result(out_last_result), .out_error_code(out_error_code)
  );

  always #5 clk = ~clk;

  // Fixed-point arithmetic of the solver.
  function automatic longint clamp32(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint apply_sign(bit neg, longint unsigned m);
    if (m > 64'h1_0000_0000) m = 64'h1_0000_0000;
    return clamp32(neg ? -longint'(m) : longint'(m));
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return apply_sign((a < 0) != (b < 0), (magnitude(a) * magnitude(b)) >> FRAC);
  endfunction

  function automatic longint q_div(longint a, longint b);
    if (b == 0) return (a > 0) ? SAT_HI : ((a < 0) ? SAT_LO : 0);
    return apply_sign((a < 0) != (b < 0), (magnitude(a) << FRAC) / magnitude(b));
  endfunction

  function automatic longint q_sqrt(longint s);
    longint unsigned rem, root, bitpos;
    rem = longint'(s) << FRAC;
    root = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > rem) bitpos >>= 2;
    while (bitpos != 0) begin
      if (rem >= root + bitpos) begin
        rem -= root + bitpos;
        root = (root >> 1) + bitpos;
      end else begin
        root >>= 1;
      end
      bitpos >>= 2;
    end
    return longint'(root);
  endfunction

  // Factor one accepted row and, on the last row, queue the back-substituted solution.
  task automatic predict_row(longint d, longint b, bit last);
    longint s, num, p, f, xv, xn;
    int n, r;
    if (rows_held < ROW_DEPTH) begin
      s = d;
      num = b;
      if (rows_held > 0) begin
        f = q_div(offdiag_q, pivot_mem[rows_held-1]);
        factor_mem[rows_held-1] = f;
        s = clamp32(d - q_mul(f, f));
        num = clamp32(b - q_mul(f, forward_mem[rows_held-1]));
      end
      if (s <= 0) begin
        pivot_bad = 1'b1;
        p = 0;
      end else begin
        p = q_sqrt(s);
      end
      pivot_mem[rows_held] = p;
      forward_mem[rows_held] = q_div(num, p);
      rows_held++;
    end
    if (!last) return;
    n = rows_held;
    xn = 0;
    for (int k = 0; k < n; k++) begin
      solved_row_t e;
      r = n - 1 - k;
      f = (k == 0) ? 0 : factor_mem[r];
      if (k == 0) xv = q_div(forward_mem[r], pivot_mem[r]);
      else xv = q_div(clamp32(forward_mem[r] - q_mul(f, xn)), pivot_mem[r]);
      xn = xv;
      e.row = r[5:0];
      e.x = xv[31:0];
      e.piv = pivot_mem[r][30:0];
      e.fac = f[31:0];
      e.last = (r == 0);
      e.err = pivot_bad;
      solution_q.push_back(e);
    end
    rows_held = 0;
    pivot_bad = 1'b0;
  endtask

  // Offer one row transaction, with an optional idle burst first.
  task automatic send_row(logic signed [31:0] d, logic signed [31:0] b, bit last);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_diag_value = d;
    in_rhs_value = b;
    in_last_row = last;
    do @(posedge clk); while (!in_ready);
    predict_row(d, b, last);
  endtask

  // Stop offering rows and wait until every queued solution has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (solution_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_offdiag(logic signed [31:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    offdiag_q = v;
  endtask

  task automatic send_random_system(int len, bit noisy);
    logic signed [31:0] d, b;
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        d = $urandom;
        b = $urandom;
      end else begin
        d = $urandom_range(6 * 65536, 40 * 65536);
        b = $signed($urandom_range(0, 200 * 65536)) - 100 * 65536;
      end
      send_row(d, b, i == len - 1);
    end
  endtask

  // Well-conditioned off-diagonal in roughly [-2, 2].
  function automatic logic signed [31:0] mild_offdiag();
    return $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
  endfunction

  // Diagonal system straight after reset, with the register at its reset value.
  task automatic test_reset_offdiag();
    send_row(4 * ONE_Q, 8 * ONE_Q, 1'b0);
    send_row(ONE_Q, -3 * ONE_Q, 1'b0);
    send_row(9 * ONE_Q, ONE_Q, 1'b1);
    wait_drained();
  endtask

  // Field extremes, degenerate pivots, a one-row system and register extremes.
  task automatic test_directed();
    write_offdiag(ONE_Q);
    send_row(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    send_row(32'sh0000_0001, 32'sh0000_0000, 1'b1);
    send_row(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_row(32'sh0000_0000, 32'sh8000_0000, 1'b0);
    send_row(4 * ONE_Q, -ONE_Q, 1'b1);
    send_row(2 * ONE_Q, 5 * ONE_Q, 1'b1);
    send_row(0, 0, 1'b1);
    wait_drained();
    write_offdiag(32'sh7FFF_FFFF);
    send_row(ONE_Q, ONE_Q, 1'b0);
    send_row(32'sh7FFF_FFFF, -ONE_Q, 1'b0);
    send_row(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    wait_drained();
    write_offdiag(32'sh8000_0000);
    send_row(32'sh7FFF_FFFF, ONE_Q, 1'b0);
    send_row(ONE_Q, 32'sh7FFF_FFFF, 1'b0);
    send_row(32'sh0001_8000, 0, 1'b1);
    wait_drained();
  endtask

  // A full-depth system, then one that overflows, with the two rows beyond the depth dropped.
  task automatic test_full_depth();
    write_offdiag(32'sh0000_8000);
    send_random_system(ROW_DEPTH, 1'b0);
    wait_drained();
    write_offdiag(-32'sh0000_C000);
    send_random_system(ROW_DEPTH + 2, 1'b0);
    wait_drained();
  endtask

  // Random short systems, changing the off-diagonal between batches.
  task automatic test_random_systems();
    int sent;
    sent = 0;
    while (sent < 80) begin
      int len;
      case ($urandom_range(0, 5))
        0: write_offdiag($urandom);
        1: write_offdiag(32'sh7FFF_FFFF);
        default: write_offdiag(mild_offdiag());
      endcase
      repeat ($urandom_range(1, 4)) begin
        len = $urandom_range(1, 8);
        send_random_system(len, 1'b1);
        sent += len;
      end
      wait_drained();
    end
  endtask

  // Long receiver hold-off while a further system is already on offer.
  task automatic test_backpressure();
    write_offdiag(mild_offdiag());
    sink_hold_req = 3000;
    send_random_system(5, 1'b0);
    send_random_system(4, 1'b0);
    wait_drained();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_streaming();
    idle_on = 1'b0;
    write_offdiag(mild_offdiag());
    repeat (4) send_random_system($urandom_range(2, 6), 1'b0);
    wait_drained();
  endtask

  // Receiver readiness with random stall bursts and an optional long hold.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (sink_hold_req > 0) begin
        stall = sink_hold_req;
        sink_hold_req = 0;
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        stall = $urandom_range(1, 15) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare each result transaction with the oldest queued solution.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (solution_q.size() == 0) begin
        $error("unexpected result transaction for row %0d", out_row_index);
        fail_count++;
      end else begin
        solved_row_t e;
        e = solution_q.pop_front();
        check_field("row_index", e.row, out_row_index);
        check_field("solution", e.x, out_solution);
        check_field("pivot", e.piv, out_pivot);
        check_field("factor_offdiag", e.fac, out_factor_offdiag);
        check_field("last_result", e.last, out_last_result);
        check_field("error_code", e.err, out_error_code);
      end
    end
  end

  initial begin
    #20ms;
    $display("tridiagonal_cholesky_solver_core verification failed");
    $finish;
  end

  initial begin
    offdiag_q = 0;
    rows_held = 0;
    pivot_bad = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_reset_offdiag();
    test_directed();
    test_full_depth();
    test_random_systems();
    test_backpressure();
    test_streaming();
    if (solution_q.size() != 0) begin
      $error("%0d expected results never arrived", solution_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tridiagonal_cholesky_solver_core verification clean");
    end else begin
      $display("tridiagonal_cholesky_solver_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tcs_pkg.sv
sv/tcs_mul.sv
sv/tcs_div.sv
sv/tcs_sqrt.sv
sv/tridiagonal_cholesky_solver_core.sv
test/tb_tridiagonal_cholesky_solver_core.sv
